[rtl/aiq_pkg.sv]
`timescale 1ns / 1ps

package aiq_pkg;

    localparam int CHANNELS = 64;
    localparam int CHAN_W   = $clog2(CHANNELS);
    localparam int Q_DEPTH  = 2;

    localparam logic [6:0] CHAN_LIMIT = 7'(CHANNELS);

    localparam logic [1:0] CFG_OPEN_DELAY        = 2'd0;
    localparam logic [1:0] CFG_REMINDER_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_CLOSE_DELAY       = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;

    localparam logic [1:0] EV_OPENED    = 2'd0;
    localparam logic [1:0] EV_REMINDER  = 2'd1;
    localparam logic [1:0] EV_RECOVERED = 2'd2;

    typedef logic [CHAN_W-1:0] chan_idx_t;

    typedef struct packed {
        logic [5:0]  channel;
        logic [1:0]  status;
        logic [47:0] now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [5:0]  event_channel;
        logic [1:0]  severity;
        logic [31:0] hit_count;
        logic [47:0] opened_time;
        logic [47:0] event_time;
    } out_item_t;

    typedef struct packed {
        logic [31:0] onset_hold;
        logic [31:0] reminder_interval;
        logic [31:0] calm_hold;
    } cfg_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } q_head_t;

    typedef struct packed {
        logic [47:0] first_problem_time;
        logic        first_problem_valid;
        logic [47:0] last_notice_time;
        logic [47:0] recovery_start_time;
        logic        recovery_pending;
        logic [31:0] problem_count;
        logic        incident_active;
        logic        ever_opened;
        logic [1:0]  last_severity;
    } entry_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

endpackage

[rtl/aiq_front.sv]
`timescale 1ns / 1ps

module aiq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  aiq_pkg::in_item_t item,
    output logic              push,
    output aiq_pkg::in_item_t push_item,
    input  logic              q_full
);
    import aiq_pkg::*;

    logic     stage_valid_reg;
    logic     stage_valid_next;
    in_item_t stage_item_reg;
    logic     in_range;
    logic     take;

    // channels beyond the table are dropped here
    assign in_range   = ({1'b0, item.channel} < CHAN_LIMIT);
    assign push       = stage_valid_reg && !q_full;
    assign push_item  = stage_item_reg;
    assign item_stall = stage_valid_reg && q_full;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (push)
        begin
            stage_valid_next = 1'b0;
        end
        if (take)
        begin
            stage_valid_next = in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg <= item;
        end
    end

endmodule

[rtl/aiq_queue.sv]
`timescale 1ns / 1ps

module aiq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  aiq_pkg::in_item_t push_item,
    output logic              full,
    output aiq_pkg::q_head_t  head,
    input  logic              pop
);
    import aiq_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    in_item_t          slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == (PTR_W + 1)'(Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/aiq_back.sv]
`timescale 1ns / 1ps

module aiq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  aiq_pkg::cfg_t      cfg,
    input  aiq_pkg::q_head_t   head,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output aiq_pkg::out_item_t result
);
    import aiq_pkg::*;

    entry_t        table_mem [CHANNELS];
    logic [CHANNELS-1:0] entry_valid_reg;

    bk_state_t     state_reg;
    bk_state_t     state_next;
    in_item_t      cur_reg;
    entry_t        rd_data_reg;
    logic          rd_valid_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_data_reg;

    chan_idx_t     rd_idx;
    chan_idx_t     cur_idx;
    entry_t        e;
    entry_t        n;
    logic          emit;
    logic [1:0]    kind;
    logic [47:0]   opened_time;
    logic          wipe;
    logic          slot_free;
    logic          commit;

    function automatic logic reached(
        input logic [47:0] now,
        input logic [47:0] ref_time,
        input logic [31:0] delay
    );
        logic [48:0] diff;
        diff = {1'b0, now} - {1'b0, ref_time};
        if (diff[48])
        begin
            return (delay == '0);
        end
        return (diff[47:0] >= {16'b0, delay});
    endfunction

    assign rd_idx       = head.item.channel[CHAN_W-1:0];
    assign cur_idx      = cur_reg.channel[CHAN_W-1:0];
    assign e            = rd_valid_reg ? rd_data_reg : '0;
    assign slot_free    = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_comb
    begin
        n           = e;
        emit        = 1'b0;
        kind        = EV_OPENED;
        opened_time = e.first_problem_time;
        wipe        = 1'b0;
        if (cur_reg.status != ST_OK)
        begin
            if (!e.first_problem_valid)
            begin
                n.first_problem_valid = 1'b1;
                n.first_problem_time  = cur_reg.now;
            end
            n.recovery_pending = 1'b0;
            if (e.problem_count != '1)
            begin
                n.problem_count = e.problem_count + 1'b1;
            end
            opened_time = n.first_problem_time;
            if (!e.incident_active
                && reached(cur_reg.now, n.first_problem_time, cfg.onset_hold))
            begin
                n.incident_active  = 1'b1;
                n.ever_opened      = 1'b1;
                n.last_severity    = cur_reg.status;
                n.last_notice_time = cur_reg.now;
                emit               = 1'b1;
                kind               = EV_OPENED;
            end
            else if (e.incident_active)
            begin
                n.last_severity = cur_reg.status;
                if (reached(cur_reg.now, e.last_notice_time, cfg.reminder_interval))
                begin
                    n.last_notice_time = cur_reg.now;
                    emit               = 1'b1;
                    kind               = EV_REMINDER;
                end
            end
        end
        else if (e.incident_active)
        begin
            if (!e.recovery_pending)
            begin
                n.recovery_pending    = 1'b1;
                n.recovery_start_time = cur_reg.now;
            end
            if (reached(cur_reg.now, n.recovery_start_time, cfg.calm_hold))
            begin
                n.incident_active     = 1'b0;
                n.first_problem_valid = 1'b0;
                n.first_problem_time  = '0;
                emit                  = 1'b1;
                kind                  = EV_RECOVERED;
            end
        end
        else if (!e.ever_opened)
        begin
            wipe = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        commit         = 1'b0;
        out_valid_next = out_valid_reg && result_stall;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!emit || slot_free)
                begin
                    commit     = 1'b1;
                    state_next = BK_IDLE;
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                rd_valid_reg <= entry_valid_reg[rd_idx];
            end
            if (commit)
            begin
                entry_valid_reg[cur_idx] <= !wipe;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg     <= head.item;
            rd_data_reg <= table_mem[rd_idx];
        end
        if (commit)
        begin
            table_mem[cur_idx] <= n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && emit)
        begin
            out_data_reg.event_kind    <= kind;
            out_data_reg.event_channel <= cur_reg.channel;
            out_data_reg.severity      <= n.last_severity;
            out_data_reg.hit_count     <= n.problem_count;
            out_data_reg.opened_time   <= opened_time;
            out_data_reg.event_time    <= cur_reg.now;
        end
    end

endmodule

[rtl/alarm_incident_qualifier.sv]
`timescale 1ns / 1ps
// Path: an accepted check result passes the front register, the queue, the
//   back end table read and the result register. The back end reads, then
//   writes back, the channel table entry of one check result at a time.
// Reset: delays cleared to zero, every table entry marked invalid (reads as
//   zero); no clearing pass, the block takes input right after reset.
module alarm_incident_qualifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  aiq_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output aiq_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import aiq_pkg::*;

    cfg_t     cfg_reg;
    logic     push;
    in_item_t push_item;
    logic     q_full;
    q_head_t  head;
    logic     pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OPEN_DELAY:        cfg_reg.onset_hold        <= cfg_data;
                CFG_REMINDER_INTERVAL: cfg_reg.reminder_interval <= cfg_data;
                CFG_CLOSE_DELAY:       cfg_reg.calm_hold         <= cfg_data;
                default:               ;
            endcase
        end
    end

    aiq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    aiq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .head      (head),
        .pop       (pop)
    );

    aiq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
